// ===== hdl/lkv_pkg.sv =====
// Package for the LRU key/value cache: sizes, operation codes, payload and cell control types.
// Used by lkv_cell and lru_key_value_cache_unit.
package lkv_pkg;

	localparam int ENTRIES     = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;

	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CAP_W  = 5;
	localparam int OCC_W  = 5;
	localparam int DATA_W = 32;
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int ADDR_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;
	localparam logic             REG_CAPACITY = 1'b0;
	localparam logic [DATA_W-1:0] CNT_MAX     = '1;

	typedef enum logic [1:0] {
		OP_GET      = 2'd0,
		OP_PUT      = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_CLEAR    = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [DATA_W-1:0]   key;
		logic [DATA_W-1:0]   value;
	} req_t;

	typedef struct packed {
		logic                found;
		logic [DATA_W-1:0]   read_value;
		logic [OCC_W-1:0]    occupancy;
		logic [DATA_W-1:0]   hit_count;
		logic [DATA_W-1:0]   miss_count;
	} rsp_t;

	typedef struct packed {
		logic update;
		logic shift;
		logic valid_next;
	} cell_ctrl_t;

endpackage

// ===== hdl/lkv_cell.sv =====
// One slot of the recency row: key, value and valid bit, with its key compare.
// Depends on lkv_pkg; chained to its neighbors by lru_key_value_cache_unit.
module lkv_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lkv_pkg::cell_ctrl_t              ctrl,
	input  logic [lkv_pkg::KEY_WIDTH-1:0]    lookup_key,
	input  logic [lkv_pkg::KEY_WIDTH-1:0]    prev_key,
	input  logic [lkv_pkg::VALUE_WIDTH-1:0]  prev_value,
	input  logic                             hit_up_in,
	input  logic [lkv_pkg::VALUE_WIDTH-1:0]  sel_value_in,
	output logic [lkv_pkg::KEY_WIDTH-1:0]    key,
	output logic [lkv_pkg::VALUE_WIDTH-1:0]  value,
	output logic                             hit,
	output logic                             hit_up_out,
	output logic [lkv_pkg::VALUE_WIDTH-1:0]  sel_value_out,
	output logic                             valid
);
	import lkv_pkg::*;

	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   valid_q;

	assign key           = key_q;
	assign value         = value_q;
	assign valid         = valid_q;
	assign hit           = valid_q && (key_q == lookup_key);
	assign hit_up_out    = hit | hit_up_in;
	assign sel_value_out = (hit ? value_q : '0) | sel_value_in;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.update) begin
			valid_q <= ctrl.valid_next;
		end
	end

endmodule

// ===== hdl/lru_key_value_cache_unit.sv =====
// Top level of the fully associative LRU key/value cache: request/response channels,
// APB capacity register, occupancy and hit/miss counters. Depends on lkv_pkg and lkv_cell.
//
// Usage:
//   Requests (req) carry kind, key and value: get, put, contains or clear.
//   Each transfer yields exactly one response (rsp) with found, read_value,
//   occupancy and the saturating hit and miss counts.
//   The entries sit in a row of cells, most recent first. All cells compare
//   the key at once; a move to front or an insert shifts the row by one slot.
//   Latency: the response is valid in the cycle after the request transfer.
//   Throughput: one item per cycle while responses are taken, set by the combinational key
//   compare and one-step shift of the cell row; the response register frees req_ready
//   in the same cycle as the response is taken.
//   A stalled response holds and blocks further requests until taken.
//   Reset empties the store, zeroes the counters and sets capacity to 16.
//   Capacity sits at byte address 0; the user must write it only while idle (not enforced by the block).
module lru_key_value_cache_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  lkv_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output lkv_pkg::rsp_t               rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkv_pkg::ADDR_W-1:0]  paddr,
	input  logic [lkv_pkg::DATA_W-1:0]  pwdata,
	output logic [lkv_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import lkv_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] hit_q;
	logic [DATA_W-1:0] miss_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic                   accept;
	logic [KEY_WIDTH-1:0]   lookup_key;
	logic [VALUE_WIDTH-1:0] front_value;
	logic                   any_hit;
	logic [CMP_W-1:0]       cap_w;
	logic [CMP_W-1:0]       eff_cap;
	logic [CMP_W-1:0]       count_w;
	logic [CMP_W-1:0]       keep_cnt;
	logic [CNT_W-1:0]       next_count;
	logic                   hit_shift;
	logic                   ins_shift;

	logic [KEY_WIDTH-1:0]   key_vec   [ENTRIES];
	logic [VALUE_WIDTH-1:0] value_vec [ENTRIES];
	logic                   hit_up    [ENTRIES+1];
	logic [VALUE_WIDTH-1:0] sel_val   [ENTRIES+1];
	logic [ENTRIES-1:0]     hit_vec;
	logic [ENTRIES-1:0]     valid_vec;

	assign req_ready  = !rsp_valid_q || rsp_ready;
	assign accept     = req_valid && req_ready;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign lookup_key = KEY_WIDTH'(req.key);
	assign any_hit    = hit_up[0];

	assign hit_up[ENTRIES]  = 1'b0;
	assign sel_val[ENTRIES] = '0;

	assign front_value = (req.kind == OP_PUT) ? VALUE_WIDTH'(req.value) : sel_val[0];

	always_comb begin
		cap_w   = CMP_W'(cap_q);
		count_w = CMP_W'(count_q);
		eff_cap = cap_w;
		if (cap_w == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_w > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end
		keep_cnt = (count_w >= eff_cap) ? (eff_cap - CMP_W'(1)) : count_w;
	end

	always_comb begin
		hit_shift  = 1'b0;
		ins_shift  = 1'b0;
		next_count = count_q;
		case (req.kind)
			OP_GET: begin
				hit_shift = any_hit;
			end
			OP_PUT: begin
				hit_shift = any_hit;
				ins_shift = !any_hit;
				if (!any_hit) begin
					next_count = CNT_W'(keep_cnt + CMP_W'(1));
				end
			end
			OP_CONTAINS: begin
				next_count = count_q;
			end
			OP_CLEAR: begin
				next_count = '0;
			end
			default: begin
				next_count = count_q;
			end
		endcase
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		cell_ctrl_t             ctrl;
		logic [KEY_WIDTH-1:0]   prev_key;
		logic [VALUE_WIDTH-1:0] prev_value;

		assign ctrl.update     = accept;
		assign ctrl.shift      = accept && ((hit_shift && hit_up[i])
			|| (ins_shift && (CMP_W'(i) <= keep_cnt)));
		assign ctrl.valid_next = CNT_W'(i) < next_count;

		if (i == 0) begin : g_head
			assign prev_key   = lookup_key;
			assign prev_value = front_value;
		end else begin : g_body
			assign prev_key   = key_vec[i-1];
			assign prev_value = value_vec[i-1];
		end

		lkv_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.lookup_key    (lookup_key),
			.prev_key      (prev_key),
			.prev_value    (prev_value),
			.hit_up_in     (hit_up[i+1]),
			.sel_value_in  (sel_val[i+1]),
			.key           (key_vec[i]),
			.value         (value_vec[i]),
			.hit           (hit_vec[i]),
			.hit_up_out    (hit_up[i]),
			.sel_value_out (sel_val[i]),
			.valid         (valid_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= next_count;
				rsp_valid_q <= 1'b1;
				case (req.kind)
					OP_GET: begin
						if (any_hit && hit_q != CNT_MAX) begin
							hit_q <= hit_q + DATA_W'(1);
						end
						if (!any_hit && miss_q != CNT_MAX) begin
							miss_q <= miss_q + DATA_W'(1);
						end
					end
					OP_CLEAR: begin
						hit_q  <= '0;
						miss_q <= '0;
					end
					default: begin
						hit_q <= hit_q;
					end
				endcase
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.found      <= any_hit && (req.kind == OP_GET || req.kind == OP_CONTAINS);
			rsp_q.read_value <= (any_hit && req.kind == OP_GET) ? DATA_W'(sel_val[0]) : '0;
			rsp_q.occupancy  <= OCC_W'(next_count);
			rsp_q.hit_count  <= (req.kind == OP_CLEAR) ? '0 :
				((req.kind == OP_GET && any_hit && hit_q != CNT_MAX) ? hit_q + DATA_W'(1) : hit_q);
			rsp_q.miss_count <= (req.kind == OP_CLEAR) ? '0 :
				((req.kind == OP_GET && !any_hit && miss_q != CNT_MAX) ?
					miss_q + DATA_W'(1) : miss_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_q) : '0;

`ifndef SYNTH
	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("valid bits disagree with occupancy");

	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("key matched in more than one slot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= ENTRIES)
		else $error("occupancy above entry count");

	a_hit_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == OP_GET && any_hit && hit_q != CNT_MAX)
		|=> (hit_q == $past(hit_q) + DATA_W'(1)))
		else $error("hit counter did not advance");
`endif

endmodule

// ===== tb/tb_lru_key_value_cache_unit.sv =====
// Self-checking testbench for lru_key_value_cache_unit: directed and random get, put,
// contains and clear traffic over several capacity settings, checked against an LRU model.
// Depends on lkv_pkg and the cache RTL.
module tb_lru_key_value_cache_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lkv_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));
	localparam int POOL_SIZE = 48;

	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_BURSTY} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	lru_key_value_cache_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [KEY_WIDTH-1:0]   lru_keys [ENTRIES];
	logic [VALUE_WIDTH-1:0] lru_vals [ENTRIES];
	int                     lru_count = 0;
	logic [DATA_W-1:0]      lru_hits = '0;
	logic [DATA_W-1:0]      lru_misses = '0;
	logic [CAP_W-1:0]       lru_capacity = CAP_RESET;

	rsp_t owed_rsp [$];
	int   error_count = 0;
	int   burst_left = 0;

	function automatic int effective_capacity(logic [CAP_W-1:0] cap);
		if (cap == 0)
			return 1;
		if (int'(cap) > ENTRIES)
			return ENTRIES;
		return int'(cap);
	endfunction

	function automatic void lru_promote(int slot);
		logic [KEY_WIDTH-1:0]   k;
		logic [VALUE_WIDTH-1:0] v;
		k = lru_keys[slot];
		v = lru_vals[slot];
		for (int i = slot; i > 0; i--) begin
			lru_keys[i] = lru_keys[i-1];
			lru_vals[i] = lru_vals[i-1];
		end
		lru_keys[0] = k;
		lru_vals[0] = v;
	endfunction

	function automatic rsp_t lru_access(req_t op);
		rsp_t res;
		int   slot;
		int   cap;
		res = '0;
		slot = -1;
		for (int i = 0; i < lru_count; i++)
			if (slot < 0 && lru_keys[i] == op.key)
				slot = i;
		case (op.kind)
			OP_GET: begin
				if (slot >= 0) begin
					lru_promote(slot);
					res.found = 1'b1;
					res.read_value = lru_vals[0];
					if (lru_hits != CNT_MAX)
						lru_hits++;
				end else if (lru_misses != CNT_MAX) begin
					lru_misses++;
				end
			end
			OP_PUT: begin
				if (slot >= 0) begin
					lru_vals[slot] = op.value;
					lru_promote(slot);
				end else begin
					cap = effective_capacity(lru_capacity);
					if (lru_count >= cap)
						lru_count = cap - 1;
					for (int i = lru_count; i > 0; i--) begin
						lru_keys[i] = lru_keys[i-1];
						lru_vals[i] = lru_vals[i-1];
					end
					lru_keys[0] = op.key;
					lru_vals[0] = op.value;
					lru_count++;
				end
			end
			OP_CONTAINS: begin
				res.found = (slot >= 0);
			end
			default: begin
				lru_count = 0;
				lru_hits = '0;
				lru_misses = '0;
			end
		endcase
		res.occupancy = OCC_W'(lru_count);
		res.hit_count = lru_hits;
		res.miss_count = lru_misses;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
		error_count++;
	endtask

	// Send one request; gaps fall between bursts of random length.
	task automatic issue_op(op_kind_t kind, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
		req_t item;
		int   gap;
		item.kind = kind;
		item.key = key;
		item.value = value;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		owed_rsp.push_back(lru_access(item));
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (owed_rsp.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write capacity while idle, then read it back.
	task automatic write_capacity(logic [CAP_W-1:0] cap);
		logic [DATA_W-1:0] word;
		drain();
		word = $urandom;
		word[CAP_W-1:0] = cap;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		lru_capacity = cap;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[CAP_W-1:0] !== lru_capacity)
			report_mismatch("capacity readback", DATA_W'(prdata[CAP_W-1:0]),
				DATA_W'(lru_capacity));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_basic_ops();
		issue_op(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		issue_op(OP_CONTAINS, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_op(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		issue_op(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
		issue_op(OP_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_op(OP_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
		issue_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
		issue_op(OP_GET, 32'h8000_0001, 32'hFFFF_FFFF);
		issue_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
	endtask

	task automatic test_small_capacity();
		write_capacity(5'd2);
		issue_op(OP_PUT, 32'h0000_0001, 32'h1111_1111);
		issue_op(OP_PUT, 32'h0000_0002, 32'h2222_2222);
		issue_op(OP_PUT, 32'h0000_0003, 32'h3333_3333);
		issue_op(OP_GET, 32'h0000_0001, 32'h0000_0000);
		issue_op(OP_CONTAINS, 32'h0000_0002, 32'h0000_0000);
	endtask

	task automatic test_capacity_bounds();
		write_capacity(5'd0);
		issue_op(OP_PUT, 32'h0000_0004, 32'h4444_4444);
		issue_op(OP_GET, 32'h0000_0003, 32'h0000_0000);
		write_capacity(5'd31);
		issue_op(OP_PUT, 32'h0000_0005, 32'h5555_5555);
		issue_op(OP_PUT, 32'h0000_0006, 32'h6666_6666);
		issue_op(OP_PUT, 32'h0000_0007, 32'h7777_7777);
	endtask

	task automatic test_capacity_shrink();
		write_capacity(5'd1);
		issue_op(OP_PUT, 32'h0000_0008, 32'h8888_8888);
		issue_op(OP_CONTAINS, 32'h0000_0007, 32'h0000_0000);
	endtask

	task automatic test_random_traffic(int n_ops, logic [CAP_W-1:0] cap);
		logic [DATA_W-1:0] key_pool [POOL_SIZE];
		logic [DATA_W-1:0] key;
		op_kind_t          kind;
		int                span;
		int                pick;
		write_capacity(cap);
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		span = effective_capacity(cap) + $urandom_range(1, 8);
		for (int n = 0; n < n_ops; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				kind = OP_GET;
			else if (pick < 75)
				kind = OP_PUT;
			else if (pick < 97)
				kind = OP_CONTAINS;
			else
				kind = OP_CLEAR;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				key = $urandom;
			else if (pick == 1)
				key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			else
				key = key_pool[$urandom_range(0, span - 1)];
			issue_op(kind, key, $urandom);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (owed_rsp.size() == 0) begin
				$display("[%0t] response with none outstanding", $realtime);
				error_count++;
			end else begin
				want = owed_rsp.pop_front();
				if (rsp.found !== want.found)
					report_mismatch("found", DATA_W'(rsp.found), DATA_W'(want.found));
				if (rsp.read_value !== want.read_value)
					report_mismatch("read_value", rsp.read_value, want.read_value);
				if (rsp.occupancy !== want.occupancy)
					report_mismatch("occupancy", DATA_W'(rsp.occupancy),
						DATA_W'(want.occupancy));
				if (rsp.hit_count !== want.hit_count)
					report_mismatch("hit_count", rsp.hit_count, want.hit_count);
				if (rsp.miss_count !== want.miss_count)
					report_mismatch("miss_count", rsp.miss_count, want.miss_count);
			end
		end
	end

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_mode_left = 0;
	int       rx_stall_left = 0;

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(20, 200);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			RX_OPEN: rsp_ready <= 1'b1;
			RX_HALF: rsp_ready <= $urandom_range(0, 1);
			RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
			default: begin
				if (rx_stall_left > 0) begin
					rsp_ready <= 1'b0;
					rx_stall_left--;
				end else begin
					rsp_ready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						rx_stall_left = $urandom_range(5, 30);
				end
			end
		endcase
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_small_capacity();
		test_capacity_bounds();
		test_capacity_shrink();
		test_random_traffic(190, 5'd16);
		test_random_traffic(190, 5'd31);
		test_random_traffic(190, 5'd3);
		test_random_traffic(190, 5'd0);
		test_random_traffic(190, 5'd17);
		test_random_traffic(190, 5'd8);
		test_random_traffic(190, 5'd1);
		test_random_traffic(190, CAP_W'($urandom_range(0, 31)));
		test_random_traffic(190, 5'd16);
		drain();
		repeat (5) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
